>>> rtl/core/tatp_pkg.sv
// Shared types and constants for the two-axis tracking PID controller.
`default_nettype none

package tatp_pkg;

   localparam logic [7:0] HEAD_MARK = 8'hBB;
   localparam logic [7:0] TAIL_MARK = 8'hFF;
   localparam logic [7:0] FOUND_MARK = 8'h01;
   localparam logic [10:0] IDLE_MAX = 11'd2047;

   localparam logic signed [15:0] KP_RESET = 16'sd256;
   localparam logic signed [15:0] KI_RESET = 16'sd0;
   localparam logic signed [15:0] KD_RESET = 16'sd0;
   localparam logic [14:0] YAW_LIMIT_RESET = 15'd60;
   localparam logic [14:0] PITCH_LIMIT_RESET = 15'd100;

   typedef enum logic [2:0] {
      CSR_KP_YAW = 3'd0,
      CSR_KI_YAW = 3'd1,
      CSR_KD_YAW = 3'd2,
      CSR_KP_PITCH = 3'd3,
      CSR_KI_PITCH = 3'd4,
      CSR_KD_PITCH = 3'd5,
      CSR_YAW_LIMIT = 3'd6,
      CSR_PITCH_LIMIT = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CAUSE_TRACK = 2'd0,
      CAUSE_LOST = 2'd1,
      CAUSE_STOP = 2'd2
   } cause_type;

   typedef struct packed {
      logic signed [15:0] kp;
      logic signed [15:0] ki;
      logic signed [15:0] kd;
      logic [14:0] limit;
   } axis_gain_type;

   typedef struct packed {
      logic run;
      logic clear;
   } axis_ctrl_type;

   typedef struct packed {
      logic [7:0] frame_tail;
      logic signed [15:0] dy;
      logic signed [15:0] dx;
      logic [7:0] found_flag;
      logic [7:0] frame_head;
   } frame_type;

endpackage

`default_nettype wire

>>> rtl/core/tatp_csr.sv
// Gain and limit registers written through the configuration channel.
`default_nettype none

module tatp_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data,
   output tatp_pkg::axis_gain_type yaw_gain,
   output tatp_pkg::axis_gain_type pitch_gain
);
   import tatp_pkg::*;

   axis_gain_type yaw_ff, yaw_in;
   axis_gain_type pitch_ff, pitch_in;

   always_comb begin
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_YAW: yaw_in.kp = csr_data;
            CSR_KI_YAW: yaw_in.ki = csr_data;
            CSR_KD_YAW: yaw_in.kd = csr_data;
            CSR_KP_PITCH: pitch_in.kp = csr_data;
            CSR_KI_PITCH: pitch_in.ki = csr_data;
            CSR_KD_PITCH: pitch_in.kd = csr_data;
            CSR_YAW_LIMIT: yaw_in.limit = csr_data[14:0];
            CSR_PITCH_LIMIT: pitch_in.limit = csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, limit: YAW_LIMIT_RESET};
         pitch_ff <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET,
                       limit: PITCH_LIMIT_RESET};
      end else begin
         yaw_ff <= yaw_in;
         pitch_ff <= pitch_in;
      end
   end

   assign yaw_gain = yaw_ff;
   assign pitch_gain = pitch_ff;

endmodule

`default_nettype wire

>>> rtl/core/tatp_axis.sv
// Positional PID for one axis with deadband, integral clamp and output saturation.
`default_nettype none

module tatp_axis #(
   parameter int INTEG_CLAMP = 100,
   parameter int DEADBAND = 5
) (
   input wire logic clock,
   input wire logic reset,
   input tatp_pkg::axis_gain_type gain,
   input tatp_pkg::axis_ctrl_type ctrl,
   input wire logic signed [15:0] offset,
   output logic signed [23:0] velocity
);
   import tatp_pkg::*;

   localparam logic [16:0] DEADBAND_W = 17'(DEADBAND);
   localparam logic signed [17:0] ILIM_POS = 18'(INTEG_CLAMP);
   localparam logic signed [17:0] ILIM_NEG = -18'(INTEG_CLAMP);

   logic signed [15:0] integral_ff, integral_in;
   logic signed [16:0] prev_err_ff, prev_err_in;

   logic signed [16:0] err_raw;
   logic [16:0] err_mag;
   logic signed [16:0] err;
   logic signed [17:0] acc_sum;
   logic signed [15:0] acc;
   logic signed [17:0] diff;
   logic signed [32:0] p_term;
   logic signed [31:0] i_term;
   logic signed [33:0] d_term;
   logic signed [35:0] total;
   logic signed [35:0] lim_pos;
   logic signed [35:0] lim_neg;
   logic signed [35:0] sat;

   always_comb begin
      err_raw = -17'(offset);
      err_mag = err_raw[16] ? 17'(-err_raw) : err_raw;
      err = (err_mag < DEADBAND_W) ? '0 : err_raw;

      acc_sum = 18'(integral_ff) + 18'(err);
      if (acc_sum > ILIM_POS) begin
         acc = 16'(ILIM_POS);
      end else if (acc_sum < ILIM_NEG) begin
         acc = 16'(ILIM_NEG);
      end else begin
         acc = 16'(acc_sum);
      end

      diff = 18'(err) - 18'(prev_err_ff);
      p_term = 33'(gain.kp) * 33'(err);
      i_term = 32'(gain.ki) * 32'(acc);
      d_term = 34'(gain.kd) * 34'(diff);
      total = 36'(p_term) + 36'(i_term) + 36'(d_term);

      lim_pos = $signed({13'd0, gain.limit, 8'd0});
      lim_neg = -lim_pos;
      if (total > lim_pos) begin
         sat = lim_pos;
      end else if (total < lim_neg) begin
         sat = lim_neg;
      end else begin
         sat = total;
      end
      velocity = sat[23:0];

      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      if (ctrl.clear) begin
         integral_in = '0;
         prev_err_in = '0;
      end else if (ctrl.run) begin
         integral_in = acc;
         prev_err_in = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_err_ff <= '0;
      end else begin
         integral_ff <= integral_in;
         prev_err_ff <= prev_err_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/two_axis_tracking_pid.sv
// Top level of the two-axis tracking PID controller.
// An accepted item is held in the input register, and its result is then registered in the output register.
// Throughput: one item per cycle while rsp_tready does not stall the output, set by the update of the PID state.
// Reset clears the integrals, previous errors and idle tick count at once and
// returns the gains and limits to their defaults; no clearing pass is needed.
`default_nettype none

module two_axis_tracking_pid #(
   parameter int INTEG_CLAMP = 100,
   parameter int DEADBAND = 5,
   parameter int TIMEOUT_TICKS = 1000
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // frame_head, found_flag, dx, dy, frame_tail
   input wire logic [55:0] req_tdata,
   // mode
   input wire logic req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // yaw_velocity, pitch_velocity
   output logic [47:0] rsp_tdata,
   // cause
   output logic [1:0] rsp_tuser,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data
);
   import tatp_pkg::*;

   localparam logic [10:0] TIMEOUT_W = 11'(TIMEOUT_TICKS);

   axis_gain_type yaw_gain;
   axis_gain_type pitch_gain;
   axis_ctrl_type axis_ctrl;

   logic in_valid_ff, in_valid_in;
   logic mode_ff, mode_in;
   frame_type frame_ff, frame_in;
   logic [10:0] idle_ff, idle_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] yaw_ff, yaw_in;
   logic signed [23:0] pitch_ff, pitch_in;
   cause_type cause_ff, cause_in;

   logic advance;
   logic fire;
   logic frame_ok;
   logic found;
   logic [10:0] idle_next;
   logic timeout;
   logic signed [23:0] yaw_velocity;
   logic signed [23:0] pitch_velocity;

   tatp_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .yaw_gain(yaw_gain),
      .pitch_gain(pitch_gain)
   );

   tatp_axis #(
      .INTEG_CLAMP(INTEG_CLAMP),
      .DEADBAND(DEADBAND)
   ) u_yaw (
      .clock(clock),
      .reset(reset),
      .gain(yaw_gain),
      .ctrl(axis_ctrl),
      .offset(frame_ff.dx),
      .velocity(yaw_velocity)
   );

   tatp_axis #(
      .INTEG_CLAMP(INTEG_CLAMP),
      .DEADBAND(DEADBAND)
   ) u_pitch (
      .clock(clock),
      .reset(reset),
      .gain(pitch_gain),
      .ctrl(axis_ctrl),
      .offset(frame_ff.dy),
      .velocity(pitch_velocity)
   );

   always_comb begin
      advance = !rsp_valid_ff || rsp_tready;
      fire = in_valid_ff && advance;
      req_tready = !in_valid_ff || advance;

      frame_ok = (frame_ff.frame_head == HEAD_MARK) && (frame_ff.frame_tail == TAIL_MARK);
      found = frame_ff.found_flag == FOUND_MARK;
      idle_next = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 11'd1;
      timeout = idle_next > TIMEOUT_W;

      axis_ctrl.run = fire && !mode_ff && frame_ok && found;
      axis_ctrl.clear = fire && !mode_ff && frame_ok && !found;

      in_valid_in = in_valid_ff;
      mode_in = mode_ff;
      frame_in = frame_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         mode_in = req_tuser;
         frame_in = frame_type'(req_tdata);
      end

      idle_in = idle_ff;
      if (fire) begin
         if (mode_ff) begin
            idle_in = idle_next;
         end else if (frame_ok) begin
            idle_in = '0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      cause_in = cause_ff;
      if (advance) begin
         rsp_valid_in = fire && (mode_ff ? timeout : frame_ok);
         if (mode_ff) begin
            cause_in = CAUSE_STOP;
            yaw_in = '0;
            pitch_in = '0;
         end else if (found) begin
            cause_in = CAUSE_TRACK;
            yaw_in = yaw_velocity;
            pitch_in = pitch_velocity;
         end else begin
            cause_in = CAUSE_LOST;
            yaw_in = '0;
            pitch_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         idle_ff <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      frame_ff <= frame_in;
      yaw_ff <= yaw_in;
      pitch_ff <= pitch_in;
      cause_ff <= cause_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {pitch_ff, yaw_ff};
   assign rsp_tuser = cause_ff;

   a_stop_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (cause_ff == CAUSE_STOP || cause_ff == CAUSE_LOST) |-> rsp_tdata == '0)
      else $error("Stop or lost item carries nonzero velocity.");

   a_frame_clears_idle: assert property (@(posedge clock) disable iff (reset)
      fire && !mode_ff && frame_ok |=> idle_ff == '0)
      else $error("Valid frame did not clear the idle count.");

   a_idle_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(fire && !mode_ff) |=> idle_ff >= $past(idle_ff))
      else $error("Idle count dropped without a frame.");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && !rsp_tready && in_valid_ff)
      else $error("Input stalled while the output could advance.");

   a_axis_ctrl_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(axis_ctrl.run && axis_ctrl.clear))
      else $error("Axis run and clear asserted together.");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-axis tracking PID controller.

module tb_top;
   import tatp_pkg::*;

   localparam int INTEG_CLAMP = 100;
   localparam int DEADBAND = 5;
   localparam int TIMEOUT_TICKS = 1000;
   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_TICK = 1'b1;
   localparam int YAW = 0;
   localparam int PITCH = 1;
   localparam int RANDOM_PHASES = 5;

   typedef struct {
      logic [23:0] yaw;
      logic [23:0] pitch;
      cause_type cause;
   } velocity_type;

   class velocity_scoreboard;
      logic signed [15:0] kp [2];
      logic signed [15:0] ki [2];
      logic signed [15:0] kd [2];
      logic [14:0] out_limit [2];
      int integral [2];
      int prev_err [2];
      int unsigned idle_ticks;
      velocity_type pending [$];
      int mismatches;
      int items;
      int results;
      int tracks;
      int losses;
      int stops;

      function new();
         kp[YAW] = KP_RESET;
         ki[YAW] = KI_RESET;
         kd[YAW] = KD_RESET;
         kp[PITCH] = KP_RESET;
         ki[PITCH] = KI_RESET;
         kd[PITCH] = KD_RESET;
         out_limit[YAW] = YAW_LIMIT_RESET;
         out_limit[PITCH] = PITCH_LIMIT_RESET;
         integral[YAW] = 0;
         integral[PITCH] = 0;
         prev_err[YAW] = 0;
         prev_err[PITCH] = 0;
         idle_ticks = 0;
         mismatches = 0;
         items = 0;
         results = 0;
         tracks = 0;
         losses = 0;
         stops = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_KP_YAW: kp[YAW] = value;
            CSR_KI_YAW: ki[YAW] = value;
            CSR_KD_YAW: kd[YAW] = value;
            CSR_KP_PITCH: kp[PITCH] = value;
            CSR_KI_PITCH: ki[PITCH] = value;
            CSR_KD_PITCH: kd[PITCH] = value;
            CSR_YAW_LIMIT: out_limit[YAW] = value[14:0];
            CSR_PITCH_LIMIT: out_limit[PITCH] = value[14:0];
            default: ;
         endcase
      endfunction

      function logic [23:0] axis_velocity(int ax, logic signed [15:0] offset);
         int err;
         int mag;
         int acc;
         longint sum;
         longint bound;
         err = -int'(offset);
         mag = (err < 0) ? -err : err;
         if (mag < DEADBAND)
            err = 0;
         acc = integral[ax] + err;
         if (acc > INTEG_CLAMP)
            acc = INTEG_CLAMP;
         else if (acc < -INTEG_CLAMP)
            acc = -INTEG_CLAMP;
         integral[ax] = acc;
         sum = longint'(kp[ax]) * err + longint'(ki[ax]) * acc
             + longint'(kd[ax]) * longint'(err - prev_err[ax]);
         bound = longint'(out_limit[ax]) * 256;
         if (sum > bound)
            sum = bound;
         else if (sum < -bound)
            sum = -bound;
         prev_err[ax] = err;
         return sum[23:0];
      endfunction

      function void note_item(logic mode, frame_type f);
         velocity_type v;
         items++;
         v.yaw = '0;
         v.pitch = '0;
         if (mode == MODE_TICK) begin
            if (idle_ticks < IDLE_MAX)
               idle_ticks++;
            if (idle_ticks > TIMEOUT_TICKS) begin
               v.cause = CAUSE_STOP;
               pending.push_back(v);
            end
            return;
         end
         if (f.frame_head != HEAD_MARK || f.frame_tail != TAIL_MARK)
            return;
         idle_ticks = 0;
         if (f.found_flag == FOUND_MARK) begin
            v.yaw = axis_velocity(YAW, f.dx);
            v.pitch = axis_velocity(PITCH, f.dy);
            v.cause = CAUSE_TRACK;
         end else begin
            integral[YAW] = 0;
            integral[PITCH] = 0;
            prev_err[YAW] = 0;
            prev_err[PITCH] = 0;
            v.cause = CAUSE_LOST;
         end
         pending.push_back(v);
      endfunction

      function void check_result(logic [47:0] data, logic [1:0] cause);
         velocity_type want;
         results++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result yaw=%h pitch=%h cause=%0d",
                        $realtime, data[23:0], data[47:24], cause);
            return;
         end
         want = pending.pop_front();
         case (want.cause)
            CAUSE_TRACK: tracks++;
            CAUSE_LOST: losses++;
            default: stops++;
         endcase
         if (data[23:0] !== want.yaw || data[47:24] !== want.pitch || cause !== want.cause) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch yaw=%h/%h pitch=%h/%h cause=%0d/%0d (actual/expected)",
                        $realtime, data[23:0], want.yaw, data[47:24], want.pitch,
                        cause, want.cause);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [55:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   velocity_scoreboard sb;
   int burst_left = 0;
   int ready_style = 0;
   int style_left = 0;
   int stall_phase = 0;

   two_axis_tracking_pid dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_item(req_tuser, frame_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style <= $urandom_range(0, 2);
         style_left <= $urandom_range(20, 300);
      end else begin
         style_left <= style_left - 1;
      end
      stall_phase <= (stall_phase + 1) % 16;
      case (ready_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 60);
         default: rsp_tready <= (stall_phase >= 10);
      endcase
   end

   function automatic frame_type make_frame(logic [7:0] head, logic [7:0] found,
                                            logic signed [15:0] dx,
                                            logic signed [15:0] dy,
                                            logic [7:0] tail);
      frame_type f;
      f.frame_head = head;
      f.found_flag = found;
      f.dx = dx;
      f.dy = dy;
      f.frame_tail = tail;
      return f;
   endfunction

   task automatic send_item(input logic mode, input frame_type f);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= f;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(logic [7:0] found, logic signed [15:0] dx, logic signed [15:0] dy);
      send_item(MODE_FRAME, make_frame(HEAD_MARK, found, dx, dy, TAIL_MARK));
   endtask

   task automatic send_tick();
      logic [63:0] noise;
      noise = {$urandom(), $urandom()};
      send_item(MODE_TICK, noise[55:0]);
   endtask

   task automatic send_random();
      logic [63:0] noise;
      frame_type f;
      logic mode;
      int pick;
      int near;
      noise = {$urandom(), $urandom()};
      f = noise[55:0];
      mode = MODE_FRAME;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         mode = MODE_TICK;
      end else if (pick < 15) begin
         // Fully random content; almost always a malformed frame.
      end else if (pick < 18) begin
         f.frame_head = HEAD_MARK;
      end else if (pick < 20) begin
         f.frame_tail = TAIL_MARK;
      end else begin
         f.frame_head = HEAD_MARK;
         f.frame_tail = TAIL_MARK;
         if (pick >= 26)
            f.found_flag = FOUND_MARK;
         if ($urandom_range(0, 1)) begin
            near = $urandom_range(0, 40);
            f.dx = 16'(near - 20);
         end
         if ($urandom_range(0, 1)) begin
            near = $urandom_range(0, 40);
            f.dy = 16'(near - 20);
         end
      end
      send_item(mode, f);
   endtask

   task automatic program_regs(input logic [15:0] values [8]);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(csr_index_type'(i), values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [15:0] regs [8];
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= MODE_FRAME;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_KP_YAW;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_tick();
      send_frame(FOUND_MARK, 16'sd0, 16'sd0);
      send_frame(FOUND_MARK, 16'sd4, -16'sd4);
      send_frame(FOUND_MARK, 16'sd5, -16'sd5);
      send_frame(FOUND_MARK, -16'sd5, 16'sd5);
      send_frame(FOUND_MARK, 16'sh7FFF, 16'sh8000);
      send_frame(FOUND_MARK, 16'sh8000, 16'sh7FFF);
      send_frame(8'h00, 16'sd300, 16'sd300);
      send_frame(8'h02, 16'sd10, 16'sd10);
      send_frame(8'hFF, -16'sd10, -16'sd10);
      send_item(MODE_FRAME, make_frame(8'hBA, FOUND_MARK, 16'sd50, 16'sd50, TAIL_MARK));
      send_item(MODE_FRAME, make_frame(HEAD_MARK, FOUND_MARK, 16'sd50, 16'sd50, 8'hFE));
      send_item(MODE_FRAME, make_frame(8'h00, 8'h00, 16'sd0, 16'sd0, 8'h00));
      send_frame(FOUND_MARK, 16'sd60, -16'sd60);
      settle();

      regs = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
               16'hFFFF, 16'h7FFF};
      program_regs(regs);
      send_frame(FOUND_MARK, 16'sh7FFF, 16'sh8000);
      send_frame(FOUND_MARK, 16'sh8000, 16'sh7FFF);
      send_frame(FOUND_MARK, 16'sd0, 16'sd0);
      send_frame(FOUND_MARK, -16'sd3, 16'sd3);
      send_frame(FOUND_MARK, 16'sd200, -16'sd200);
      send_frame(8'h00, 16'sd0, 16'sd0);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: regs = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                        16'h7FFF, 16'hFFFF};
            1: regs = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                        16'h0000, 16'h8000};
            2: regs = '{KP_RESET, KI_RESET, KD_RESET, KP_RESET, KI_RESET, KD_RESET,
                        {1'b0, YAW_LIMIT_RESET}, {1'b0, PITCH_LIMIT_RESET}};
            default: begin
               for (int i = 0; i < 6; i++)
                  regs[i] = $urandom_range(0, 1) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 2047) - 1024);
               regs[6] = 16'($urandom());
               regs[7] = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 200));
            end
         endcase
         program_regs(regs);
         repeat (40) send_random();
         settle();
      end

      // Long silence: stops just past the timeout, with a malformed frame that
      // must not restart the count.
      send_frame(FOUND_MARK, 16'sd7, -16'sd7);
      for (int i = 0; i < 1003; i++) begin
         send_tick();
         if (i == 500)
            send_item(MODE_FRAME, make_frame(HEAD_MARK, FOUND_MARK, 16'sd9, 16'sd9, 8'h7F));
      end
      send_frame(8'h00, 16'sd0, 16'sd0);
      repeat (5) send_tick();
      send_frame(FOUND_MARK, 16'sd40, -16'sd40);
      send_tick();
      settle();

      if (sb.pending.size() != 0)
         $display("%0d expected results never arrived", sb.pending.size());
      $display("Covered %0d items and %0d results: %0d tracking, %0d target lost, %0d stops.",
               sb.items, sb.results, sb.tracks, sb.losses, sb.stops);
      $display("Gains and limits went through %0d settings, extremes included; %0d mismatches.",
               RANDOM_PHASES + 2, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tatp_pkg.sv
rtl/core/tatp_csr.sv
rtl/core/tatp_axis.sv
rtl/core/two_axis_tracking_pid.sv
verif/tb_top.sv
